// ===== rtl/dwpid_pkg.sv =====
// Shared types, constants and register map of the dual wheel PID drive.
// Used by the register file, sequencer, datapath and top; it depends on nothing else.
`timescale 1ns / 1ps

package dwpid_pkg;

  localparam int COEF_FRAC_BITS_DEF  = 16;
  localparam int SPEED_FRAC_BITS_DEF = 8;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int DUTY_MAX = 255;
  localparam int NUM_MULS = 8;

  localparam logic [23:0] COEF_NOW_RST    = 24'd168786;
  localparam logic [23:0] COEF_PREV_RST   = 24'hFDFED8;  // -131368
  localparam logic [23:0] COEF_PREV2_RST  = 24'd3932;
  localparam logic [23:0] SPEED_SCALE_RST = 24'd64758;
  localparam logic [7:0]  BOOST_LEFT_RST  = 8'd8;
  localparam logic [7:0]  TRIM_RIGHT_RST  = 8'd0;

  typedef enum logic [2:0] {
    REG_COEF_NOW    = 3'd0,
    REG_COEF_PREV   = 3'd1,
    REG_COEF_PREV2  = 3'd2,
    REG_SPEED_SCALE = 3'd3,
    REG_BOOST_LEFT  = 3'd4,
    REG_TRIM_RIGHT  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    MUL_SPD_L   = 3'd0,
    MUL_SPD_R   = 3'd1,
    MUL_NOW_L   = 3'd2,
    MUL_NOW_R   = 3'd3,
    MUL_PREV_L  = 3'd4,
    MUL_PREV_R  = 3'd5,
    MUL_PREV2_L = 3'd6,
    MUL_PREV2_R = 3'd7
  } mul_op_e;

  typedef enum logic [2:0] {
    ACC_NONE  = 3'd0,
    ACC_SPD_L = 3'd1,
    ACC_SPD_R = 3'd2,
    ACC_PID_L = 3'd3,
    ACC_PID_R = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic [23:0] coef_now;
    logic [23:0] coef_prev;
    logic [23:0] coef_prev2;
    logic [23:0] speed_scale;
    logic [7:0]  boost_left;
    logic [7:0]  trim_right;
  } cfg_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_e mul_op;
    acc_op_e acc_op;
    logic    clamp;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/dwpid_in_if.sv =====
// Input channel of the PID drive: one control tick per item.
// Standalone; field widths are fixed by the item format.
`timescale 1ns / 1ps

interface dwpid_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] count_left;
  logic signed [15:0] count_right;
  logic signed [23:0] set_left;
  logic signed [23:0] set_right;

  modport source (output valid, count_left, count_right, set_left, set_right,
                  input ready);
  modport sink   (input valid, count_left, count_right, set_left, set_right,
                  output ready);
endinterface

// ===== rtl/dwpid_out_if.sv =====
// Output channel of the PID drive: motor commands and measured speeds.
// Standalone; field widths are fixed by the item format.
`timescale 1ns / 1ps

interface dwpid_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         dir_left;
  logic [7:0]         rear_duty_left;
  logic [7:0]         front_duty_left;
  logic [1:0]         dir_right;
  logic [7:0]         rear_duty_right;
  logic [7:0]         front_duty_right;
  logic signed [23:0] speed_left;
  logic signed [23:0] speed_right;

  modport source (output valid, dir_left, rear_duty_left, front_duty_left, dir_right,
                  rear_duty_right, front_duty_right, speed_left, speed_right,
                  input ready);
  modport sink   (input valid, dir_left, rear_duty_left, front_duty_left, dir_right,
                  rear_duty_right, front_duty_right, speed_left, speed_right,
                  output ready);
endinterface

// ===== rtl/dwpid_regs.sv =====
// APB register file holding the PID coefficients, speed scale and duty offsets.
// Depends on dwpid_pkg.
`timescale 1ns / 1ps

module dwpid_regs
  import dwpid_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_COEF_NOW:    cfg_d.coef_now    = pwdata[23:0];
        REG_COEF_PREV:   cfg_d.coef_prev   = pwdata[23:0];
        REG_COEF_PREV2:  cfg_d.coef_prev2  = pwdata[23:0];
        REG_SPEED_SCALE: cfg_d.speed_scale = pwdata[23:0];
        REG_BOOST_LEFT:  cfg_d.boost_left  = pwdata[7:0];
        REG_TRIM_RIGHT:  cfg_d.trim_right  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COEF_NOW:    prdata = {8'd0, cfg_q.coef_now};
      REG_COEF_PREV:   prdata = {8'd0, cfg_q.coef_prev};
      REG_COEF_PREV2:  prdata = {8'd0, cfg_q.coef_prev2};
      REG_SPEED_SCALE: prdata = {8'd0, cfg_q.speed_scale};
      REG_BOOST_LEFT:  prdata = {24'd0, cfg_q.boost_left};
      REG_TRIM_RIGHT:  prdata = {24'd0, cfg_q.trim_right};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_now    <= COEF_NOW_RST;
      cfg_q.coef_prev   <= COEF_PREV_RST;
      cfg_q.coef_prev2  <= COEF_PREV2_RST;
      cfg_q.speed_scale <= SPEED_SCALE_RST;
      cfg_q.boost_left  <= BOOST_LEFT_RST;
      cfg_q.trim_right  <= TRIM_RIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/dwpid_ctrl.sv =====
// Sequencer of the PID drive: steps the shared multiplier through eight products,
// then clamps and hands the item to the output register. Depends on dwpid_pkg.
`timescale 1ns / 1ps

module dwpid_ctrl
  import dwpid_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_ready_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_RUN   = 2'd1,
    S_CLAMP = 2'd2,
    S_EMIT  = 2'd3
  } state_e;

  state_e      state_q;
  logic [3:0]  step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          step_q <= '0;
          if (stat_i.in_valid) state_q <= S_RUN;
        end
        S_RUN: begin
          // The last step only drains the product register.
          if (step_q == 4'(NUM_MULS)) state_q <= S_CLAMP;
          step_q <= step_q + 4'd1;
        end
        S_CLAMP: state_q <= S_EMIT;
        S_EMIT: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_op = MUL_SPD_L;
    cmd_o.acc_op = ACC_NONE;
    cmd_o.load   = (state_q == S_IDLE) && stat_i.in_valid;
    cmd_o.clamp  = (state_q == S_CLAMP);
    cmd_o.emit   = (state_q == S_EMIT) && stat_i.out_free;
    if (state_q == S_RUN) begin
      cmd_o.mul_en = (step_q < 4'(NUM_MULS));
      unique case (step_q[2:0])
        3'd0: cmd_o.mul_op = MUL_SPD_L;
        3'd1: cmd_o.mul_op = MUL_SPD_R;
        3'd2: cmd_o.mul_op = MUL_NOW_L;
        3'd3: cmd_o.mul_op = MUL_NOW_R;
        3'd4: cmd_o.mul_op = MUL_PREV_L;
        3'd5: cmd_o.mul_op = MUL_PREV_R;
        3'd6: cmd_o.mul_op = MUL_PREV2_L;
        default: cmd_o.mul_op = MUL_PREV2_R;
      endcase
      // Each product is consumed in the step after it was issued.
      unique case (step_q)
        4'd1: cmd_o.acc_op = ACC_SPD_L;
        4'd2: cmd_o.acc_op = ACC_SPD_R;
        4'd3, 4'd5, 4'd7: cmd_o.acc_op = ACC_PID_L;
        4'd4, 4'd6, 4'd8: cmd_o.acc_op = ACC_PID_R;
        default: cmd_o.acc_op = ACC_NONE;
      endcase
    end
  end

endmodule

// ===== rtl/dwpid_dp.sv =====
// Datapath of the PID drive: input capture, shared 25x25 multiplier, accumulators,
// per-wheel PID state, clamp, duty mapping and output register. Depends on dwpid_pkg.
`timescale 1ns / 1ps

module dwpid_dp
  import dwpid_pkg::*;
#(
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  input  logic signed [15:0] count_left_i,
  input  logic signed [15:0] count_right_i,
  input  logic signed [23:0] set_left_i,
  input  logic signed [23:0] set_right_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_free_o,
  output logic [1:0]         dir_left_o,
  output logic [7:0]         rear_duty_left_o,
  output logic [7:0]         front_duty_left_o,
  output logic [1:0]         dir_right_o,
  output logic [7:0]         rear_duty_right_o,
  output logic [7:0]         front_duty_right_o,
  output logic signed [23:0] speed_left_o,
  output logic signed [23:0] speed_right_o
);

  localparam int OP_W    = 25;
  localparam int PROD_W  = 2 * OP_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SUM_W   = ACC_W + 1;
  localparam int DRIVE_W = SPEED_FRAC_BITS + 9;
  localparam int SHR = (COEF_FRAC_BITS >= SPEED_FRAC_BITS) ?
                       COEF_FRAC_BITS - SPEED_FRAC_BITS : 0;
  localparam int SHL = (SPEED_FRAC_BITS > COEF_FRAC_BITS) ?
                       SPEED_FRAC_BITS - COEF_FRAC_BITS : 0;
  localparam logic signed [PROD_W-1:0] SPD_HI = PROD_W'(8388607);
  localparam logic signed [PROD_W-1:0] SPD_LO = -PROD_W'(8388608);
  localparam logic signed [SUM_W-1:0]  LIM_HI = SUM_W'(DUTY_MAX) <<< SPEED_FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  LIM_LO = -LIM_HI;

  typedef struct packed {
    dir_e       dir;
    logic [7:0] rear;
    logic [7:0] front;
  } drive_t;

  function automatic drive_t map_drive(input logic signed [DRIVE_W-1:0] v,
                                       input logic is_left,
                                       input logic [7:0] boost,
                                       input logic [7:0] trim);
    drive_t             r;
    logic [DRIVE_W-1:0] mag;
    logic [8:0]         sum;
    r   = '0;
    mag = v[DRIVE_W-1] ? DRIVE_W'(-v) : DRIVE_W'(v);
    sum = '0;
    if (v == '0) begin
      r.dir = DIR_STOP;
    end else begin
      r.dir  = v[DRIVE_W-1] ? DIR_REV : DIR_FWD;
      r.rear = mag[SPEED_FRAC_BITS +: 8];
      if (is_left) begin
        sum     = {1'b0, r.rear} + {1'b0, boost};
        r.front = sum[8] ? 8'(DUTY_MAX) : sum[7:0];
      end else begin
        r.front = (r.rear > trim) ? r.rear - trim : 8'd0;
      end
    end
    return r;
  endfunction

  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
      input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > LIM_HI) c = LIM_HI;
    else if (v < LIM_LO) c = LIM_LO;
    return c[DRIVE_W-1:0];
  endfunction

  // Item registers.
  logic signed [16:0]        cnt_l_q, cnt_r_q;
  logic signed [23:0]        set_l_q, set_r_q;
  logic signed [23:0]        spd_l_q, spd_r_q;
  logic signed [24:0]        err_l_q, err_r_q;
  logic signed [ACC_W-1:0]   acc_l_q, acc_r_q;
  logic signed [PROD_W-1:0]  prod_q;
  // PID state kept across items.
  logic signed [DRIVE_W-1:0] last_l_q, last_r_q;
  logic signed [24:0]        e1_l_q, e2_l_q, e1_r_q, e2_r_q;
  // Output register.
  logic                      out_valid_q;
  drive_t                    drv_l_q, drv_r_q;
  logic signed [23:0]        out_spd_l_q, out_spd_r_q;

  logic signed [OP_W-1:0]    op_a, op_b;
  logic signed [PROD_W-1:0]  spd_wide;
  logic signed [23:0]        spd_sat;
  logic signed [23:0]        set_sel;
  logic signed [24:0]        err_new;
  logic signed [SUM_W-1:0]   sum_l, sum_r;

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_SPD_L:   begin op_a = OP_W'(cnt_l_q);            op_b = {1'b0, cfg_i.speed_scale}; end
      MUL_SPD_R:   begin op_a = OP_W'(cnt_r_q);            op_b = {1'b0, cfg_i.speed_scale}; end
      MUL_NOW_L:   begin op_a = OP_W'($signed(cfg_i.coef_now));   op_b = err_l_q; end
      MUL_NOW_R:   begin op_a = OP_W'($signed(cfg_i.coef_now));   op_b = err_r_q; end
      MUL_PREV_L:  begin op_a = OP_W'($signed(cfg_i.coef_prev));  op_b = e1_l_q;  end
      MUL_PREV_R:  begin op_a = OP_W'($signed(cfg_i.coef_prev));  op_b = e1_r_q;  end
      MUL_PREV2_L: begin op_a = OP_W'($signed(cfg_i.coef_prev2)); op_b = e2_l_q;  end
      default:     begin op_a = OP_W'($signed(cfg_i.coef_prev2)); op_b = e2_r_q;  end
    endcase
  end

  // Speed from the registered count product: floor shift into Q.SPEED, then saturate.
  always_comb begin
    spd_wide = (prod_q >>> SHR) <<< SHL;
    if (spd_wide > SPD_HI)      spd_sat = 24'sh7FFFFF;
    else if (spd_wide < SPD_LO) spd_sat = 24'sh800000;
    else                        spd_sat = spd_wide[23:0];
    set_sel = (cmd_i.acc_op == ACC_SPD_L) ? set_l_q : set_r_q;
    err_new = 25'(set_sel) - 25'(spd_sat);
  end

  assign sum_l = SUM_W'(last_l_q) + SUM_W'(acc_l_q >>> COEF_FRAC_BITS);
  assign sum_r = SUM_W'(last_r_q) + SUM_W'(acc_r_q >>> COEF_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnt_l_q <= -17'(count_left_i);
      cnt_r_q <= 17'(count_right_i);
      set_l_q <= set_left_i;
      set_r_q <= set_right_i;
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else begin
      unique case (cmd_i.acc_op)
        ACC_SPD_L: begin spd_l_q <= spd_sat; err_l_q <= err_new; end
        ACC_SPD_R: begin spd_r_q <= spd_sat; err_r_q <= err_new; end
        ACC_PID_L: acc_l_q <= acc_l_q + ACC_W'(prod_q);
        ACC_PID_R: acc_r_q <= acc_r_q + ACC_W'(prod_q);
        default: ;
      endcase
    end
    if (cmd_i.mul_en) prod_q <= op_a * op_b;
    if (cmd_i.emit) begin
      drv_l_q     <= map_drive(last_l_q, 1'b1, cfg_i.boost_left, cfg_i.trim_right);
      drv_r_q     <= map_drive(last_r_q, 1'b0, cfg_i.boost_left, cfg_i.trim_right);
      out_spd_l_q <= spd_l_q;
      out_spd_r_q <= spd_r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q    <= '0;
      last_r_q    <= '0;
      e1_l_q      <= '0;
      e2_l_q      <= '0;
      e1_r_q      <= '0;
      e2_r_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clamp) begin
        last_l_q <= clamp_drive(sum_l);
        last_r_q <= clamp_drive(sum_r);
        e2_l_q   <= e1_l_q;
        e1_l_q   <= err_l_q;
        e2_r_q   <= e1_r_q;
        e1_r_q   <= err_r_q;
      end
      out_valid_q <= cmd_i.emit | (out_valid_q & ~out_ready_i);
    end
  end

  assign out_free_o         = ~out_valid_q | out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign dir_left_o         = drv_l_q.dir;
  assign rear_duty_left_o   = drv_l_q.rear;
  assign front_duty_left_o  = drv_l_q.front;
  assign dir_right_o        = drv_r_q.dir;
  assign rear_duty_right_o  = drv_r_q.rear;
  assign front_duty_right_o = drv_r_q.front;
  assign speed_left_o       = out_spd_l_q;
  assign speed_right_o      = out_spd_r_q;

endmodule

// ===== rtl/dual_wheel_incremental_pid_drive_unit.sv =====
// Channel   Direction  Handshake      Content
// in_ch     sink       valid/ready    encoder counts and speed setpoints, one tick
// out_ch    source     valid/ready    direction codes, rear/front duties, speeds
// apb       slave      psel/penable   PID coefficients, speed scale, boost, trim
//
// After acceptance, the shared 25x25 multiplier issues eight products (two
// speeds and three PID terms per wheel); a drain step, a clamp step and an
// emit step follow, and the emit places the result in the output register.
// The input is ready again in the cycle after the emit, so a new item is not
// taken before the last one is through. A new item is accepted once the
// previous result sits in the output register.
// Reset clears the PID history and last drive values to zero; registers take defaults.
// A stalled output holds its result; the next result waits until it is taken.
`timescale 1ns / 1ps

module dual_wheel_incremental_pid_drive_unit
  import dwpid_pkg::*;
#(
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dwpid_in_if.sink          in_ch,
  dwpid_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  out_free;

  dwpid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign stat.in_valid = in_ch.valid;
  assign stat.out_free = out_free;

  dwpid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ch.ready)
  );

  dwpid_dp #(
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .count_left_i       (in_ch.count_left),
    .count_right_i      (in_ch.count_right),
    .set_left_i         (in_ch.set_left),
    .set_right_i        (in_ch.set_right),
    .out_ready_i        (out_ch.ready),
    .out_valid_o        (out_ch.valid),
    .out_free_o         (out_free),
    .dir_left_o         (out_ch.dir_left),
    .rear_duty_left_o   (out_ch.rear_duty_left),
    .front_duty_left_o  (out_ch.front_duty_left),
    .dir_right_o        (out_ch.dir_right),
    .rear_duty_right_o  (out_ch.rear_duty_right),
    .front_duty_right_o (out_ch.front_duty_right),
    .speed_left_o       (out_ch.speed_left),
    .speed_right_o      (out_ch.speed_right)
  );

endmodule
